// ===== rtl/core/vtt_pkg.sv =====
package vtt_pkg;

  // Width of one velocity component, in and out (signed, 8 fraction bits)
  localparam int unsigned SAMPLE_WIDTH = 16;

  localparam int unsigned NUM_FIELDS = 6;
  localparam int unsigned TDATA_W    = ((NUM_FIELDS * SAMPLE_WIDTH + 7) / 8) * 8;

  localparam int unsigned REG_W   = 48;
  localparam int unsigned ROT_W   = 16;  // Q2.14
  localparam int unsigned TRANS_W = 16;  // Q8.8
  localparam int unsigned CFG_IDX_W = 8;

  // R*x products carry 22 fraction bits
  localparam int unsigned PROD_W  = ROT_W + SAMPLE_WIDTH;
  localparam int unsigned SUM_W   = PROD_W + 2;
  // R*w rounded to nearest at 14 fraction bits
  localparam int unsigned Q_SHIFT = 8;
  localparam int unsigned Q_W     = SUM_W + 1 - Q_SHIFT;
  localparam int unsigned CROSS_W = TRANS_W + Q_W;
  localparam int unsigned LIN_W   = CROSS_W + 2;
  localparam int unsigned OUT_SHIFT = 14;
  localparam int unsigned RND_W   = LIN_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = CFG_IDX_W'(3);

  localparam logic [REG_W-1:0] ROT_ROW0_RST    = REG_W'(48'h0000_0000_4000);
  localparam logic [REG_W-1:0] ROT_ROW1_RST    = REG_W'(48'h0000_4000_0000);
  localparam logic [REG_W-1:0] ROT_ROW2_RST    = REG_W'(48'h4000_0000_0000);
  localparam logic [REG_W-1:0] TRANSLATION_RST = '0;

  localparam logic signed [RND_W-1:0] ROUND_HALF_OUT = RND_W'(1 << (OUT_SHIFT - 1));
  localparam logic signed [RND_W-1:0] SAT_HI =
    {{(RND_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_LO =
    {{(RND_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;

  // per-stage load enables, stage 1 at the input
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } stage_en_t;

  // round to nearest (ties up) from 22 to 8 fraction bits, then clamp
  function automatic sample_t round_sat(input logic signed [RND_W-1:0] x);
    logic signed [RND_W-1:0] y;
    y = (x + ROUND_HALF_OUT) >>> OUT_SHIFT;
    if (y > SAT_HI) begin
      y = SAT_HI;
    end else if (y < SAT_LO) begin
      y = SAT_LO;
    end
    return y[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/core/vtt_lane.sv =====
// One rotation row: products in stage 1, row sums in stage 2.
module vtt_lane (
  input  logic                        clk_i,
  input  vtt_pkg::stage_en_t          en_i,
  input  logic [vtt_pkg::REG_W-1:0]   row_i,
  input  vtt_pkg::sample_t            lin_i [3],
  input  vtt_pkg::sample_t            ang_i [3],
  output vtt_pkg::sum_t               p_o,
  output vtt_pkg::sum_t               rv_o
);

  logic signed [vtt_pkg::ROT_W-1:0]  rot [3];
  logic signed [vtt_pkg::PROD_W-1:0] prod_w_d [3];
  logic signed [vtt_pkg::PROD_W-1:0] prod_w_q [3];
  logic signed [vtt_pkg::PROD_W-1:0] prod_v_d [3];
  logic signed [vtt_pkg::PROD_W-1:0] prod_v_q [3];
  vtt_pkg::sum_t p_d, p_q, rv_d, rv_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rot[j]      = $signed(row_i[j*vtt_pkg::ROT_W +: vtt_pkg::ROT_W]);
      prod_w_d[j] = rot[j] * ang_i[j];
      prod_v_d[j] = rot[j] * lin_i[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      prod_w_q <= prod_w_d;
      prod_v_q <= prod_v_d;
    end
  end

  assign p_d  = vtt_pkg::SUM_W'(prod_w_q[0]) + vtt_pkg::SUM_W'(prod_w_q[1])
              + vtt_pkg::SUM_W'(prod_w_q[2]);
  assign rv_d = vtt_pkg::SUM_W'(prod_v_q[0]) + vtt_pkg::SUM_W'(prod_v_q[1])
              + vtt_pkg::SUM_W'(prod_v_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      p_q  <= p_d;
      rv_q <= rv_d;
    end
  end

  assign p_o  = p_q;
  assign rv_o = rv_q;

endmodule

// ===== rtl/core/vtt_merge.sv =====
// Combines the three lanes: rounds R*w, forms t x (R*w), adds, rounds, clamps.
module vtt_merge (
  input  logic                        clk_i,
  input  vtt_pkg::stage_en_t          en_i,
  input  logic [vtt_pkg::REG_W-1:0]   trans_i,
  input  vtt_pkg::sum_t               p_i  [3],
  input  vtt_pkg::sum_t               rv_i [3],
  output vtt_pkg::sample_t            lin_o [3],
  output vtt_pkg::sample_t            ang_o [3]
);

  localparam logic signed [vtt_pkg::SUM_W:0] RoundHalfQ =
    (vtt_pkg::SUM_W + 1)'(1 << (vtt_pkg::Q_SHIFT - 1));

  logic signed [vtt_pkg::TRANS_W-1:0] t [3];
  logic signed [vtt_pkg::Q_W-1:0]     q_d [3];
  logic signed [vtt_pkg::Q_W-1:0]     q_q [3];
  vtt_pkg::sum_t                      rv3_q [3];
  vtt_pkg::sum_t                      rv4_q [3];
  vtt_pkg::sample_t                   ang_d [3];
  vtt_pkg::sample_t                   ang3_q [3];
  vtt_pkg::sample_t                   ang4_q [3];
  vtt_pkg::sample_t                   ang5_q [3];
  logic signed [vtt_pkg::CROSS_W-1:0] cp_d [3];
  logic signed [vtt_pkg::CROSS_W-1:0] cn_d [3];
  logic signed [vtt_pkg::CROSS_W-1:0] cp_q [3];
  logic signed [vtt_pkg::CROSS_W-1:0] cn_q [3];
  logic signed [vtt_pkg::LIN_W-1:0]   lin_sum [3];
  vtt_pkg::sample_t                   lin_d [3];
  vtt_pkg::sample_t                   lin5_q [3];

  // stage 3: round R*w to 14 fraction bits, finish the angular part
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_d[i]   = vtt_pkg::Q_W'(((vtt_pkg::SUM_W + 1)'(p_i[i]) + RoundHalfQ)
                 >>> vtt_pkg::Q_SHIFT);
      ang_d[i] = vtt_pkg::round_sat(vtt_pkg::RND_W'(p_i[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      q_q    <= q_d;
      rv3_q  <= rv_i;
      ang3_q <= ang_d;
    end
  end

  // stage 4: cross product terms, t is Q8.8 so products land on 22 fraction bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i] = $signed(trans_i[i*vtt_pkg::TRANS_W +: vtt_pkg::TRANS_W]);
    end
    cp_d[0] = t[1] * q_q[2];
    cn_d[0] = t[2] * q_q[1];
    cp_d[1] = t[2] * q_q[0];
    cn_d[1] = t[0] * q_q[2];
    cp_d[2] = t[0] * q_q[1];
    cn_d[2] = t[1] * q_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en4) begin
      cp_q   <= cp_d;
      cn_q   <= cn_d;
      rv4_q  <= rv3_q;
      ang4_q <= ang3_q;
    end
  end

  // stage 5: linear sum, round and clamp into the output register
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lin_sum[i] = vtt_pkg::LIN_W'(rv4_q[i]) + vtt_pkg::LIN_W'(cp_q[i])
                 - vtt_pkg::LIN_W'(cn_q[i]);
      lin_d[i]   = vtt_pkg::round_sat(vtt_pkg::RND_W'(lin_sum[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en5) begin
      lin5_q <= lin_d;
      ang5_q <= ang4_q;
    end
  end

  assign lin_o = lin5_q;
  assign ang_o = ang5_q;

endmodule

// ===== rtl/core/velocity_twist_transform.sv =====
// Velocity twist transform: maps a six-component velocity (linear, angular)
// into another frame, angular out = R*w and linear out = R*v + t x (R*w),
// rounded to nearest and clamped to the sample width. R (Q2.14 rows) and
// t (Q8.8) are written through the configuration channel, index 0..2 for the
// rotation rows and 3 for the translation; other indexes are dropped. Reset
// loads the identity rotation and zero translation. Write configuration only
// while no transaction is in flight. The datapath is a five-stage pipeline
// (three row lanes for products and row sums, then merge stages for rounding,
// the cross product and the final sum): it takes one transaction per clock while
// the output is not stalled, and each result passes through the stage registers
// in order to the output. Each stage holds its item when the next one is full
// and stalled, so empty stages still fill.
module velocity_twist_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z (lowest first)
  input  logic [vtt_pkg::TDATA_W-1:0]       s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z (lowest first)
  output logic [vtt_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vtt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vtt_pkg::REG_W-1:0]         cfg_data_i
);

  localparam int unsigned SW = vtt_pkg::SAMPLE_WIDTH;

  logic [vtt_pkg::REG_W-1:0] rot_row_q [3];
  logic [vtt_pkg::REG_W-1:0] trans_q;

  vtt_pkg::stage_en_t en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  vtt_pkg::sample_t lin_in  [3];
  vtt_pkg::sample_t ang_in  [3];
  vtt_pkg::sum_t    p_lane  [3];
  vtt_pkg::sum_t    rv_lane [3];
  vtt_pkg::sample_t lin_out [3];
  vtt_pkg::sample_t ang_out [3];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_row_q[0] <= vtt_pkg::ROT_ROW0_RST;
      rot_row_q[1] <= vtt_pkg::ROT_ROW1_RST;
      rot_row_q[2] <= vtt_pkg::ROT_ROW2_RST;
      trans_q      <= vtt_pkg::TRANSLATION_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vtt_pkg::REG_ROT_ROW0:    rot_row_q[0] <= cfg_data_i;
        vtt_pkg::REG_ROT_ROW1:    rot_row_q[1] <= cfg_data_i;
        vtt_pkg::REG_ROT_ROW2:    rot_row_q[2] <= cfg_data_i;
        vtt_pkg::REG_TRANSLATION: trans_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en.en5 = !v5_q || m_axis_tready;
    en.en4 = !v4_q || en.en5;
    en.en3 = !v3_q || en.en4;
    en.en2 = !v2_q || en.en3;
    en.en1 = !v1_q || en.en2;
  end

  assign s_axis_tready = en.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en.en1) v1_q <= s_axis_tvalid;
      if (en.en2) v2_q <= v1_q;
      if (en.en3) v3_q <= v2_q;
      if (en.en4) v4_q <= v3_q;
      if (en.en5) v5_q <= v4_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lin_in[i] = $signed(s_axis_tdata[i*SW +: SW]);
      ang_in[i] = $signed(s_axis_tdata[(i+3)*SW +: SW]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    vtt_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .row_i (rot_row_q[g]),
      .lin_i (lin_in),
      .ang_i (ang_in),
      .p_o   (p_lane[g]),
      .rv_o  (rv_lane[g])
    );
  end

  vtt_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .trans_i (trans_q),
    .p_i     (p_lane),
    .rv_i    (rv_lane),
    .lin_o   (lin_out),
    .ang_o   (ang_out)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[i*SW +: SW]     = lin_out[i];
      m_axis_tdata[(i+3)*SW +: SW] = ang_out[i];
    end
  end

  assign m_axis_tvalid = v5_q;

`ifndef ASSERT_OFF
  // an accepted transaction always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted transaction lost at pipeline entry");

  // a full, stalled pipeline must refuse new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && v4_q && v5_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline is full and stalled");

  // stage 4 content moving on must reach the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && en.en5 |=> m_axis_tvalid)
    else $error("item dropped between merge stages");
`endif

endmodule
